// ===== hw/rtl/pf_pkg.sv =====
// Shared types, constants and helper functions for the Playfair digraph cipher.
// No dependencies; pf_front, pf_cipher, the top level and pf_checker import it.

package pf_pkg;

  // Letter codes run A=0 .. Z=25 in five bits.
  typedef logic [4:0] letter_t;
  typedef logic [2:0] coord_t;
  typedef logic [24:0] row_t;
  typedef row_t [4:0] square_t;

  localparam int unsigned SQ_SIZE = 5;

  localparam letter_t CODE_I = 5'd8;
  localparam letter_t CODE_J = 5'd9;
  localparam letter_t CODE_X = 5'd23;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

  // Register map of the configuration port.
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECRYPT = 3'd0,
    CFG_ROW0    = 3'd1,
    CFG_ROW1    = 3'd2,
    CFG_ROW2    = 3'd3,
    CFG_ROW3    = 3'd4,
    CFG_ROW4    = 3'd5
  } cfg_reg_t;

  // Reset key square: ABCDE / FGHIK / LMNOP / QRSTU / VWXYZ.
  localparam row_t ROW0_RESET = 25'd4294688;
  localparam row_t ROW1_RESET = 25'd10755269;
  localparam row_t ROW2_RESET = 25'd16201099;
  localparam row_t ROW3_RESET = 25'd21613104;
  localparam row_t ROW4_RESET = 25'd27025109;

  // One pair waiting to be enciphered, or an empty end-of-message marker.
  typedef struct packed {
    letter_t a;
    letter_t b;
    logic    pair;
    logic    done;
  } pair_req_t;

  // Work produced by one input byte: up to two results, oldest in slot 0.
  typedef struct packed {
    logic [1:0]      cnt;
    pair_req_t [1:0] slot;
  } job_t;

  // One result as it leaves the block.
  typedef struct packed {
    letter_t first_letter;
    letter_t second_letter;
    logic    pair_valid;
    logic    message_done;
  } result_t;

  // Read the letter code at a row and column of the square.
  function automatic letter_t sq_cell(square_t sq, coord_t r, coord_t c);
    row_t    row;
    letter_t res;
    row = sq[r];
    res = '0;
    for (int j = 0; j < SQ_SIZE; j++) begin
      if (c == coord_t'(j)) begin
        res = row[j*5 +: 5];
      end
    end
    return res;
  endfunction

  // Find a letter in the square; the first match in row-major order wins,
  // and a letter that is absent sits at row 0, column 0.
  function automatic logic [5:0] locate(square_t sq, letter_t l);
    logic [5:0] pos;
    pos = '0;
    for (int i = SQ_SIZE - 1; i >= 0; i--) begin
      for (int j = SQ_SIZE - 1; j >= 0; j--) begin
        if (sq[i][j*5 +: 5] == l) begin
          pos = {coord_t'(i), coord_t'(j)};
        end
      end
    end
    return pos;
  endfunction

  // Move one place round a row or column, forward or backward.
  function automatic coord_t step5(coord_t v, logic back);
    coord_t res;
    if (back) begin
      res = (v == 3'd0) ? coord_t'(SQ_SIZE - 1) : v - 3'd1;
    end else begin
      res = (v == coord_t'(SQ_SIZE - 1)) ? 3'd0 : v + 3'd1;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/pf_in_if.sv =====
// Valid/ready channel that carries raw text bytes into the cipher.
// No dependencies.

interface pf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

// ===== hw/rtl/pf_out_if.sv =====
// Valid/ready channel that carries enciphered letter pairs out of the cipher.
// No dependencies.

interface pf_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] first_letter;
  logic [4:0] second_letter;
  logic       pair_valid;
  logic       message_done;

  modport source (output valid, output first_letter, output second_letter,
                  output pair_valid, output message_done, input ready);
  modport sink (input valid, input first_letter, input second_letter,
                input pair_valid, input message_done, output ready);
endinterface

// ===== hw/rtl/pf_front.sv =====
// Front end: filters and folds text bytes, pairs the letters and builds the
// list of pairs that each byte releases. Depends on pf_pkg.

module pf_front
  import pf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] text_byte,
  input  logic       final_byte,
  input  logic       decrypt_mode,
  output job_t       job
);

  logic    held_valid_r, held_valid_nxt;
  letter_t held_letter_r, held_letter_nxt;

  logic      is_letter;
  letter_t   raw_letter;
  letter_t   letter;
  pair_req_t first_req, second_req;
  logic [1:0] cnt;

  // Classify the byte and fold it to a letter code, J read as I.
  always_comb begin
    is_letter  = 1'b0;
    raw_letter = '0;
    if (text_byte >= ASCII_UPPER_A && text_byte <= ASCII_UPPER_Z) begin
      is_letter  = 1'b1;
      raw_letter = letter_t'(text_byte - ASCII_UPPER_A);
    end else if (text_byte >= ASCII_LOWER_A && text_byte <= ASCII_LOWER_Z) begin
      is_letter  = 1'b1;
      raw_letter = letter_t'(text_byte - ASCII_LOWER_A);
    end
    letter = (raw_letter == CODE_J) ? CODE_I : raw_letter;
  end

  // Pairing rules, then padding of a lone letter at the end of a message.
  always_comb begin
    held_valid_nxt  = held_valid_r;
    held_letter_nxt = held_letter_r;
    cnt             = 2'd0;
    first_req       = '0;
    second_req      = '0;

    if (is_letter) begin
      if (!held_valid_r) begin
        held_valid_nxt  = 1'b1;
        held_letter_nxt = letter;
      end else if (!decrypt_mode && held_letter_r == letter) begin
        // Equal letters while encrypting: split by X, keep the new letter.
        first_req       = '{a: held_letter_r, b: CODE_X, pair: 1'b1, done: 1'b0};
        cnt             = 2'd1;
        held_letter_nxt = letter;
      end else begin
        first_req       = '{a: held_letter_r, b: letter, pair: 1'b1, done: final_byte};
        cnt             = 2'd1;
        held_valid_nxt  = 1'b0;
        held_letter_nxt = '0;
      end
    end

    if (final_byte) begin
      if (held_valid_nxt) begin
        if (cnt == 2'd0) begin
          first_req = '{a: held_letter_nxt, b: CODE_X, pair: 1'b1, done: 1'b1};
        end else begin
          second_req = '{a: held_letter_nxt, b: CODE_X, pair: 1'b1, done: 1'b1};
        end
        cnt             = cnt + 2'd1;
        held_valid_nxt  = 1'b0;
        held_letter_nxt = '0;
      end else if (cnt == 2'd0) begin
        // Nothing to send: a bare end-of-message marker.
        first_req = '{a: '0, b: '0, pair: 1'b0, done: 1'b1};
        cnt       = 2'd1;
      end
    end

    job.cnt     = cnt;
    job.slot[0] = first_req;
    job.slot[1] = second_req;
  end

  // Held letter is updated only when a request is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r  <= 1'b0;
      held_letter_r <= '0;
    end else if (accept) begin
      held_valid_r  <= held_valid_nxt;
      held_letter_r <= held_letter_nxt;
    end
  end

endmodule

// ===== hw/rtl/pf_cipher.sv =====
// Digraph encipher/decipher logic: locates both letters in the key square and
// applies the row, column or rectangle rule. Depends on pf_pkg.

module pf_cipher
  import pf_pkg::*;
(
  input  square_t   square,
  input  logic      decrypt_mode,
  input  pair_req_t req,
  output result_t   res
);

  logic [5:0] pos_a, pos_b;
  coord_t     r1, c1, r2, c2;
  letter_t    o1, o2;

  // Both lookups run side by side.
  assign pos_a = locate(square, req.a);
  assign pos_b = locate(square, req.b);
  assign r1    = pos_a[5:3];
  assign c1    = pos_a[2:0];
  assign r2    = pos_b[5:3];
  assign c2    = pos_b[2:0];

  // Same row shifts columns, same column shifts rows, otherwise swap columns.
  always_comb begin
    if (r1 == r2) begin
      o1 = sq_cell(square, r1, step5(c1, decrypt_mode));
      o2 = sq_cell(square, r2, step5(c2, decrypt_mode));
    end else if (c1 == c2) begin
      o1 = sq_cell(square, step5(r1, decrypt_mode), c1);
      o2 = sq_cell(square, step5(r2, decrypt_mode), c2);
    end else begin
      o1 = sq_cell(square, r1, c2);
      o2 = sq_cell(square, r2, c1);
    end

    // An end-of-message marker carries zero letters.
    if (req.pair) begin
      res.first_letter  = o1;
      res.second_letter = o2;
    end else begin
      res.first_letter  = '0;
      res.second_letter = '0;
    end
    res.pair_valid   = req.pair;
    res.message_done = req.done;
  end

endmodule

// ===== hw/rtl/playfair_digraph_cipher.sv =====
// Top level of the Playfair digraph cipher: configuration registers, job
// register, result sequencing and output register.
// Depends on pf_pkg, pf_in_if, pf_out_if, pf_front and pf_cipher.
//
//   Channel  Direction  Payload                                      Handshake
//   in_ch    sink       text_byte[7:0], final_byte                   valid/ready
//   out_ch   source     first_letter, second_letter, pair_valid,     valid/ready
//                       message_done
//   cfg_*    sink       cfg_index[2:0], cfg_wdata[24:0]              cfg_we only
//
// A byte's pairs are enciphered one per cycle while the output register is free,
// from the job register into the output register. A byte that releases at most
// one result is taken every cycle while the sink keeps up; a byte that releases
// two keeps the next byte waiting until its second result issues. The output
// register is refilled in the cycle it is taken, so a stalled sink only holds
// the block while the job register still holds a pending result.
// Reset (synchronous, rst_n low) clears the held letter, the pending job, the
// output valid and restores the default key square with encryption selected.

module playfair_digraph_cipher
  import pf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  pf_in_if.sink                in_ch,
  pf_out_if.source             out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [24:0]          cfg_wdata
);

  logic    decrypt_r;
  square_t square_r;

  logic      [1:0] job_cnt_r, job_cnt_nxt;
  pair_req_t [1:0] job_slot_r, job_slot_nxt;
  job_t            front_job;

  logic    out_valid_r;
  result_t out_res_r;
  result_t cipher_res;

  logic out_free, issue, accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_r   <= 1'b0;
      square_r[0] <= ROW0_RESET;
      square_r[1] <= ROW1_RESET;
      square_r[2] <= ROW2_RESET;
      square_r[3] <= ROW3_RESET;
      square_r[4] <= ROW4_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DECRYPT: decrypt_r   <= cfg_wdata[0];
        CFG_ROW0:    square_r[0] <= cfg_wdata;
        CFG_ROW1:    square_r[1] <= cfg_wdata;
        CFG_ROW2:    square_r[2] <= cfg_wdata;
        CFG_ROW3:    square_r[3] <= cfg_wdata;
        CFG_ROW4:    square_r[4] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: a new request is taken once the job register will be empty.
  assign out_free     = !out_valid_r || out_ch.ready;
  assign issue        = (job_cnt_r != 2'd0) && out_free;
  assign in_ch.ready  = (job_cnt_r == 2'd0) || (issue && job_cnt_r == 2'd1);
  assign accept       = in_ch.valid && in_ch.ready;

  pf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .text_byte    (in_ch.text_byte),
    .final_byte   (in_ch.final_byte),
    .decrypt_mode (decrypt_r),
    .job          (front_job)
  );

  // Job register: load on a request, otherwise shift after each issue.
  always_comb begin
    job_cnt_nxt  = job_cnt_r;
    job_slot_nxt = job_slot_r;
    if (accept) begin
      job_cnt_nxt  = front_job.cnt;
      job_slot_nxt = front_job.slot;
    end else if (issue) begin
      job_cnt_nxt     = job_cnt_r - 2'd1;
      job_slot_nxt[0] = job_slot_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_cnt_r <= 2'd0;
    end else begin
      job_cnt_r <= job_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_slot_r <= job_slot_nxt;
  end

  pf_cipher u_cipher (
    .square       (square_r),
    .decrypt_mode (decrypt_r),
    .req          (job_slot_r[0]),
    .res          (cipher_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (issue) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_res_r <= cipher_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.first_letter  = out_res_r.first_letter;
  assign out_ch.second_letter = out_res_r.second_letter;
  assign out_ch.pair_valid    = out_res_r.pair_valid;
  assign out_ch.message_done  = out_res_r.message_done;

endmodule

// ===== hw/rtl/pf_checker.sv =====
// Port-level checks for the Playfair digraph cipher, bound to the top level.
// Depends on pf_pkg and on the port names of playfair_digraph_cipher.

module pf_checker
  import pf_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input letter_t out_first_letter,
  input letter_t out_second_letter,
  input logic    out_pair_valid,
  input logic    out_message_done
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // A result without a pair is only ever the bare end-of-message marker.
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pair_valid |->
      out_message_done && out_first_letter == 5'd0 && out_second_letter == 5'd0)
    else $error("empty result that is not an end-of-message marker");

  // Input is only refused while work is pending, which shows as a result next.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> out_valid)
    else $error("request refused with no result under way");

  // Nothing is offered straight after reset.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind playfair_digraph_cipher pf_checker u_pf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_first_letter  (out_ch.first_letter),
  .out_second_letter (out_ch.second_letter),
  .out_pair_valid    (out_ch.pair_valid),
  .out_message_done  (out_ch.message_done)
);
